// ----- sv/tpq_pkg.sv -----
// Shared constants, operation codes and helpers for the two-level priority task queue.
package tpq_pkg;

  localparam int QueueDepth = 16;
  localparam int HandleW    = 32;

  localparam int FieldW     = 32;
  localparam int OpW        = 3;
  localparam int LevelW     = 8;
  localparam int StoreW     = (HandleW < FieldW) ? HandleW : FieldW;
  localparam int EntryW     = 3 * StoreW;
  localparam int StoreDepth = 2 * QueueDepth;
  localparam int AddrW      = $clog2(StoreDepth);
  localparam int PtrW       = (QueueDepth > 2) ? $clog2(QueueDepth) : 1;
  localparam int CntW       = $clog2(QueueDepth + 1);
  localparam int MaxResults = 32;
  localparam int ResW       = $clog2(MaxResults);

  localparam int InFieldsW  = OpW + LevelW + 3 * FieldW;
  localparam int InDataW    = ((InFieldsW + 7) / 8) * 8;
  localparam int OutDataW   = 3 * FieldW;
  localparam int OutUserW   = 2;

  localparam logic [OpW-1:0] OpEnqueue = 3'd0;
  localparam logic [OpW-1:0] OpRun     = 3'd1;
  localparam logic [OpW-1:0] OpPeek    = 3'd2;
  localparam logic [OpW-1:0] OpDrain   = 3'd3;
  localparam logic [OpW-1:0] OpClear   = 3'd4;

  typedef logic [PtrW-1:0] ptr_t;
  typedef logic [CntW-1:0] cnt_t;

  function automatic logic [AddrW-1:0] slot_addr(input logic lvl, input ptr_t ptr);
    logic [AddrW-1:0] base;
    base = lvl ? AddrW'(QueueDepth) : '0;
    return base + AddrW'(ptr);
  endfunction

  function automatic ptr_t ptr_next(input ptr_t ptr);
    return (ptr == PtrW'(QueueDepth - 1)) ? '0 : ptr + 1'b1;
  endfunction

endpackage

// ----- sv/two_level_priority_task_queue.sv -----
// Two-level strict priority task queue: entry RAM, per-level pointers and result register.
//
//   channel  | dir | tdata (low bit up)                       | tuser             | tlast
//   ---------+-----+------------------------------------------+-------------------+------
//   s_*      | in  | op, level, func, arg, cleanup, zero pad  | -                 | -
//   m_*      | out | out_func, out_arg, out_cleanup           | ok, from_level    | last
//
// Enqueue, clear and any miss are handled in the idle state; run and peek also pass through the
// read state for the registered read of the entry RAM. Drain starts like a run and then reads
// entry after entry from the same RAM read port while the result register drains. Reset clears
// the state, pointers, fill counts and output valid; the entry RAM needs no clearing. A stalled
// result register holds the word and stops further reads; no new word is taken until it is done.
module two_level_priority_task_queue (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_tvalid_i,
  output logic                         s_tready_o,
  input  logic [tpq_pkg::InDataW-1:0]  s_tdata_i,  // op, level, func, arg, cleanup
  output logic                         m_tvalid_o,
  input  logic                         m_tready_i,
  output logic [tpq_pkg::OutDataW-1:0] m_tdata_o,  // out_func, out_arg, out_cleanup
  output logic [tpq_pkg::OutUserW-1:0] m_tuser_o,  // ok, from_level
  output logic                         m_tlast_o
);

  localparam logic [0:0] StIdle = 1'b0;
  localparam logic [0:0] StRead = 1'b1;

  localparam int FW = tpq_pkg::FieldW;
  localparam int SW = tpq_pkg::StoreW;

  logic [0:0]          state_q, state_d;
  tpq_pkg::ptr_t       head_q [2];
  tpq_pkg::ptr_t       head_d [2];
  tpq_pkg::ptr_t       tail_q [2];
  tpq_pkg::ptr_t       tail_d [2];
  tpq_pkg::cnt_t       cnt_q [2];
  tpq_pkg::cnt_t       cnt_d [2];
  logic                lvl_q, lvl_d;
  logic                drain_q, drain_d;
  logic [tpq_pkg::ResW-1:0] n_q, n_d;

  logic                       m_valid_q, m_valid_d;
  logic [tpq_pkg::OutDataW-1:0] m_data_q;
  logic [tpq_pkg::OutUserW-1:0] m_user_q;
  logic                       m_last_q;

  logic [tpq_pkg::OpW-1:0]    in_op;
  logic [tpq_pkg::LevelW-1:0] in_level;
  logic [FW-1:0]              in_func, in_arg, in_cleanup;

  logic                         out_free, in_acc;
  logic                         out_load, out_ok, out_lvl, out_last;
  logic [tpq_pkg::OutDataW-1:0] out_data;
  logic                         ram_we, ram_re;
  logic [tpq_pkg::AddrW-1:0]    ram_waddr, ram_raddr;
  logic [tpq_pkg::EntryW-1:0]   ram_wdata, ram_rdata;
  logic                         do_pop, do_peek, do_clear, pop_lvl, rd_lvl;
  logic                         lvl_ok, full, any_held, tail_empty;

  assign in_op      = s_tdata_i[2:0];
  assign in_level   = s_tdata_i[10:3];
  assign in_func    = s_tdata_i[42:11];
  assign in_arg     = s_tdata_i[74:43];
  assign in_cleanup = s_tdata_i[106:75];

  assign out_free   = !m_valid_q || m_tready_i;
  assign s_tready_o = (state_q == StIdle) && out_free;
  assign in_acc     = s_tvalid_i && s_tready_o;

  assign lvl_ok   = (in_level[tpq_pkg::LevelW-1:1] == '0);
  assign full     = (cnt_q[in_level[0]] == tpq_pkg::CntW'(tpq_pkg::QueueDepth));
  assign any_held = (cnt_q[1] != '0) || (cnt_q[0] != '0);
  assign pop_lvl  = (cnt_q[1] != '0);
  assign rd_lvl   = do_peek ? 1'b0 : pop_lvl;

  assign ram_waddr = tpq_pkg::slot_addr(in_level[0], tail_q[in_level[0]]);
  assign ram_wdata = {in_cleanup[SW-1:0], in_arg[SW-1:0], in_func[SW-1:0]};
  assign ram_raddr = tpq_pkg::slot_addr(rd_lvl, head_q[rd_lvl]);

  tpq_ram #(
    .Width(tpq_pkg::EntryW),
    .Depth(tpq_pkg::StoreDepth)
  ) u_entry_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    tail_d     = tail_q;
    cnt_d      = cnt_q;
    lvl_d      = lvl_q;
    drain_d    = drain_q;
    n_d        = n_q;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    do_pop     = 1'b0;
    do_peek    = 1'b0;
    do_clear   = 1'b0;
    out_load   = 1'b0;
    out_ok     = 1'b0;
    out_lvl    = 1'b0;
    out_data   = '0;
    out_last   = 1'b1;
    tail_empty = (cnt_q[1] == '0) && (cnt_q[0] == '0);

    case (state_q)
      StIdle: begin
        if (in_acc) begin
          case (in_op)
            tpq_pkg::OpEnqueue: begin
              out_load = 1'b1;
              if (lvl_ok && !full) begin
                ram_we                 = 1'b1;
                tail_d[in_level[0]]    = tpq_pkg::ptr_next(tail_q[in_level[0]]);
                cnt_d[in_level[0]]     = cnt_q[in_level[0]] + 1'b1;
                out_ok                 = 1'b1;
                out_lvl                = in_level[0];
              end
            end
            tpq_pkg::OpRun, tpq_pkg::OpDrain: begin
              if (any_held) begin
                ram_re  = 1'b1;
                do_pop  = 1'b1;
                lvl_d   = pop_lvl;
                drain_d = (in_op == tpq_pkg::OpDrain);
                n_d     = '0;
                state_d = StRead;
              end else begin
                out_load = 1'b1;
              end
            end
            tpq_pkg::OpPeek: begin
              if (cnt_q[0] != '0) begin
                do_peek = 1'b1;
                ram_re  = 1'b1;
                lvl_d   = 1'b0;
                drain_d = 1'b0;
                state_d = StRead;
              end else begin
                out_load = 1'b1;
              end
            end
            tpq_pkg::OpClear: begin
              do_clear = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      StRead: begin
        if (out_free) begin
          out_load = 1'b1;
          out_ok   = 1'b1;
          out_lvl  = lvl_q;
          out_data = {FW'(ram_rdata[3*SW-1:2*SW]), FW'(ram_rdata[2*SW-1:SW]),
                      FW'(ram_rdata[SW-1:0])};
          out_last = !drain_q || tail_empty ||
                     (n_q == tpq_pkg::ResW'(tpq_pkg::MaxResults - 1));
          if (!out_last) begin
            // advance to the next entry of the drain
            ram_re = 1'b1;
            do_pop = 1'b1;
            lvl_d  = pop_lvl;
            n_d    = n_q + 1'b1;
          end else begin
            state_d  = StIdle;
            do_clear = drain_q;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    if (do_pop) begin
      head_d[pop_lvl] = tpq_pkg::ptr_next(head_q[pop_lvl]);
      cnt_d[pop_lvl]  = cnt_q[pop_lvl] - 1'b1;
    end
    if (do_clear) begin
      head_d = '{default: '0};
      tail_d = '{default: '0};
      cnt_d  = '{default: '0};
    end
  end

  assign m_valid_d = out_load ? 1'b1 : (m_tready_i ? 1'b0 : m_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      head_q    <= '{default: '0};
      tail_q    <= '{default: '0};
      cnt_q     <= '{default: '0};
      lvl_q     <= 1'b0;
      drain_q   <= 1'b0;
      n_q       <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
      cnt_q     <= cnt_d;
      lvl_q     <= lvl_d;
      drain_q   <= drain_d;
      n_q       <= n_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_data_q <= out_data;
      m_user_q <= {out_lvl, out_ok};
      m_last_q <= out_last;
    end
  end

  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = m_data_q;
  assign m_tuser_o  = m_user_q;
  assign m_tlast_o  = m_last_q;

endmodule

// ----- sv/tpq_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module tpq_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- tb/task_queue_checker.sv -----
// Checker for the two-level priority task queue: predicts every result word and compares it.
module task_queue_checker
  import tpq_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_tvalid_i,
  input  logic                s_tready_i,
  input  logic [InDataW-1:0]  s_tdata_i,  // op, level, func, arg, cleanup
  input  logic                m_tvalid_i,
  input  logic                m_tready_i,
  input  logic [OutDataW-1:0] m_tdata_i,  // out_func, out_arg, out_cleanup
  input  logic [OutUserW-1:0] m_tuser_i,  // ok, from_level
  input  logic                m_tlast_i,
  output int                  errors_o,
  output int                  pending_o
);

  typedef struct packed {
    logic              ok;
    logic              from_level;
    logic [FieldW-1:0] func;
    logic [FieldW-1:0] arg;
    logic [FieldW-1:0] cleanup;
    logic              last;
  } task_word_t;

  logic [StoreW-1:0] func_mem    [2][QueueDepth];
  logic [StoreW-1:0] arg_mem     [2][QueueDepth];
  logic [StoreW-1:0] cleanup_mem [2][QueueDepth];
  int                head_idx [2];
  int                tail_idx [2];
  int                fill_cnt [2];
  task_word_t        awaited_words [$];

  function automatic void clear_levels();
    for (int l = 0; l < 2; l++) begin
      head_idx[l] = 0;
      tail_idx[l] = 0;
      fill_cnt[l] = 0;
    end
  endfunction

  function automatic void drop_head(input int lvl);
    head_idx[lvl] = (head_idx[lvl] + 1) % QueueDepth;
    fill_cnt[lvl]--;
  endfunction

  function automatic task_word_t status_word(input logic ok, input logic lvl);
    task_word_t w;
    w            = '0;
    w.ok         = ok;
    w.from_level = lvl;
    w.last       = 1'b1;
    return w;
  endfunction

  function automatic task_word_t entry_word(input int lvl, input logic last);
    task_word_t w;
    w.ok         = 1'b1;
    w.from_level = lvl[0];
    w.func       = FieldW'(func_mem[lvl][head_idx[lvl]]);
    w.arg        = FieldW'(arg_mem[lvl][head_idx[lvl]]);
    w.cleanup    = FieldW'(cleanup_mem[lvl][head_idx[lvl]]);
    w.last       = last;
    return w;
  endfunction

  task automatic predict_task_queue(input logic [OpW-1:0] op, input logic [LevelW-1:0] level,
                                    input logic [FieldW-1:0] f, input logic [FieldW-1:0] a,
                                    input logic [FieldW-1:0] c);
    int lvl;
    int total;
    int n;
    lvl   = 0;
    total = 0;
    n     = 0;
    case (op)
      OpEnqueue: begin
        if (level > 8'd1 || fill_cnt[level[0]] >= QueueDepth) begin
          awaited_words.push_back(status_word(1'b0, 1'b0));
        end else begin
          lvl = int'(level[0]);
          func_mem[lvl][tail_idx[lvl]]    = f[StoreW-1:0];
          arg_mem[lvl][tail_idx[lvl]]     = a[StoreW-1:0];
          cleanup_mem[lvl][tail_idx[lvl]] = c[StoreW-1:0];
          tail_idx[lvl] = (tail_idx[lvl] + 1) % QueueDepth;
          fill_cnt[lvl]++;
          awaited_words.push_back(status_word(1'b1, level[0]));
        end
      end
      OpRun: begin
        lvl = (fill_cnt[1] > 0) ? 1 : 0;
        if (fill_cnt[lvl] == 0) begin
          awaited_words.push_back(status_word(1'b0, 1'b0));
        end else begin
          awaited_words.push_back(entry_word(lvl, 1'b1));
          drop_head(lvl);
        end
      end
      OpPeek: begin
        if (fill_cnt[0] == 0) begin
          awaited_words.push_back(status_word(1'b0, 1'b0));
        end else begin
          awaited_words.push_back(entry_word(0, 1'b1));
        end
      end
      OpDrain: begin
        total = fill_cnt[0] + fill_cnt[1];
        if (total > MaxResults) total = MaxResults;
        if (total == 0) begin
          awaited_words.push_back(status_word(1'b0, 1'b0));
        end else begin
          for (lvl = 1; lvl >= 0; lvl--) begin
            while (fill_cnt[lvl] > 0) begin
              if (n < total) begin
                awaited_words.push_back(entry_word(lvl, n == total - 1));
                n++;
              end
              drop_head(lvl);
            end
          end
        end
        clear_levels();
      end
      OpClear: clear_levels();
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [FieldW-1:0] got,
                                 input logic [FieldW-1:0] want);
    $display("mismatch at %0t: %s got %h want %h", $time, what, got, want);
    errors_o++;
  endtask

  always @(posedge clk_i) begin
    task_word_t got;
    task_word_t want;
    if (!rst_ni) begin
      clear_levels();
      awaited_words.delete();
      errors_o = 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        got.ok         = m_tuser_i[0];
        got.from_level = m_tuser_i[1];
        got.func       = m_tdata_i[0 +: FieldW];
        got.arg        = m_tdata_i[FieldW +: FieldW];
        got.cleanup    = m_tdata_i[2*FieldW +: FieldW];
        got.last       = m_tlast_i;
        if (awaited_words.size() == 0) begin
          report_mismatch("word with nothing awaited, out_func", got.func, '0);
        end else begin
          want = awaited_words.pop_front();
          if (got.ok !== want.ok) report_mismatch("ok", FieldW'(got.ok), FieldW'(want.ok));
          if (got.from_level !== want.from_level)
            report_mismatch("from_level", FieldW'(got.from_level), FieldW'(want.from_level));
          if (got.func !== want.func) report_mismatch("out_func", got.func, want.func);
          if (got.arg !== want.arg) report_mismatch("out_arg", got.arg, want.arg);
          if (got.cleanup !== want.cleanup)
            report_mismatch("out_cleanup", got.cleanup, want.cleanup);
          if (got.last !== want.last)
            report_mismatch("last", FieldW'(got.last), FieldW'(want.last));
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        predict_task_queue(s_tdata_i[0 +: OpW], s_tdata_i[OpW +: LevelW],
                           s_tdata_i[OpW+LevelW +: FieldW],
                           s_tdata_i[OpW+LevelW+FieldW +: FieldW],
                           s_tdata_i[OpW+LevelW+2*FieldW +: FieldW]);
      end
    end
    pending_o = awaited_words.size();
  end

endmodule

// ----- tb/two_level_priority_task_queue_tb.sv -----
// Testbench top for the two-level priority task queue: request stimulus, result pacing, verdict.
module two_level_priority_task_queue_tb;
  import tpq_pkg::*;

  localparam int CycleLimit   = 400000;
  localparam int RandomWords  = 300;
  localparam int CalmWords    = 60;
  localparam int LongHold     = 300;
  localparam int SettleCycles = 20;

  localparam logic [OpW-1:0]    OpSpareLo = 3'd5;
  localparam logic [OpW-1:0]    OpSpareHi = 3'd7;
  localparam logic [LevelW-1:0] LevelLow  = 8'd0;
  localparam logic [LevelW-1:0] LevelHigh = 8'd1;
  localparam logic [LevelW-1:0] LevelBad  = 8'd2;
  localparam logic [LevelW-1:0] LevelTop  = 8'hFF;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                s_tvalid_i;
  logic                s_tready_o;
  logic [InDataW-1:0]  s_tdata_i;   // op, level, func, arg, cleanup
  logic                m_tvalid_o;
  logic                m_tready_i;
  logic [OutDataW-1:0] m_tdata_o;   // out_func, out_arg, out_cleanup
  logic [OutUserW-1:0] m_tuser_o;   // ok, from_level
  logic                m_tlast_o;

  int check_errors;
  int check_pending;
  int cycle_count;
  bit calm;
  bit hold_req;

  two_level_priority_task_queue u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tuser_o  (m_tuser_o),
    .m_tlast_o  (m_tlast_o)
  );

  task_queue_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_i (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .m_tvalid_i (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_i  (m_tdata_o),
    .m_tuser_i  (m_tuser_o),
    .m_tlast_i  (m_tlast_o),
    .errors_o   (check_errors),
    .pending_o  (check_pending)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("two_level_priority_task_queue regression: fail");
      $finish;
    end
  end

  function automatic logic [FieldW-1:0] pick_handle();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return FieldW'($urandom());
    endcase
  endfunction

  task automatic send_word(input logic [OpW-1:0] op, input logic [LevelW-1:0] lvl,
                           input logic [FieldW-1:0] f, input logic [FieldW-1:0] a,
                           input logic [FieldW-1:0] c);
    int gap;
    if (!calm && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 12);
      s_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tdata_i  <= {{(InDataW - InFieldsW){1'b0}}, c, a, f, lvl, op};
    @(posedge clk_i);
    while (!s_tready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    s_tvalid_i <= 1'b0;
    do @(negedge clk_i); while (check_pending != 0);
  endtask

  task automatic send_random(output bit counted);
    int                pick;
    logic [OpW-1:0]    op;
    logic [LevelW-1:0] lvl;
    pick    = $urandom_range(0, 99);
    counted = 1'b1;
    op      = OpEnqueue;
    lvl     = LevelW'($urandom());
    if (pick < 50) begin
      if ($urandom_range(0, 9) != 0) lvl = LevelW'($urandom_range(0, 1));
    end else if (pick < 75) begin
      op = OpRun;
    end else if (pick < 87) begin
      op = OpPeek;
    end else if (pick < 91) begin
      op = OpDrain;
    end else if (pick < 94) begin
      op = OpClear;
    end else begin
      op      = OpW'($urandom_range(OpSpareLo, OpSpareHi));
      counted = 1'b0;
    end
    send_word(op, lvl, pick_handle(), pick_handle(), pick_handle());
  endtask

  initial begin
    int stall_left;
    stall_left = 0;
    m_tready_i = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = LongHold;
      end
      if (stall_left > 0) begin
        m_tready_i <= 1'b0;
        stall_left--;
      end else begin
        m_tready_i <= 1'b1;
        if (!calm && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 12);
      end
    end
  end

  initial begin
    int sent;
    int burst;
    bit counted;
    bit paused;
    rst_ni     = 1'b0;
    s_tvalid_i = 1'b0;
    s_tdata_i  = '0;
    calm       = 1'b0;
    paused     = 1'b0;
    sent       = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // empty queues: misses and a silent clear
    send_word(OpRun, LevelLow, '0, '0, '0);
    send_word(OpPeek, LevelTop, '1, '1, '1);
    send_word(OpDrain, LevelLow, '0, '0, '0);
    send_word(OpClear, LevelLow, '0, '0, '0);
    // stores at both levels, handle extremes, rejected levels
    send_word(OpEnqueue, LevelLow, '0, '0, '0);
    send_word(OpEnqueue, LevelLow, '1, '1, '1);
    send_word(OpEnqueue, LevelHigh, pick_handle(), pick_handle(), '0);
    send_word(OpEnqueue, LevelHigh, '1, '1, '1);
    send_word(OpEnqueue, LevelBad, '1, '1, '1);
    send_word(OpEnqueue, LevelTop, '1, '1, '1);
    send_word(OpEnqueue, 8'h80, pick_handle(), pick_handle(), pick_handle());
    // level one wins, peek leaves the head in place
    send_word(OpPeek, LevelHigh, '0, '0, '0);
    send_word(OpRun, LevelLow, '0, '0, '0);
    send_word(OpRun, LevelLow, '0, '0, '0);
    send_word(OpRun, LevelLow, '0, '0, '0);
    send_word(OpPeek, LevelLow, '0, '0, '0);
    send_word(OpRun, LevelLow, '0, '0, '0);
    send_word(OpRun, LevelLow, '0, '0, '0);
    // short drain, clear, ignored ops
    send_word(OpEnqueue, LevelLow, pick_handle(), pick_handle(), pick_handle());
    send_word(OpEnqueue, LevelHigh, pick_handle(), pick_handle(), pick_handle());
    send_word(OpDrain, LevelLow, '0, '0, '0);
    send_word(OpEnqueue, LevelLow, pick_handle(), pick_handle(), pick_handle());
    send_word(OpClear, LevelLow, '0, '0, '0);
    send_word(OpRun, LevelLow, '0, '0, '0);
    send_word(OpSpareLo, LevelHigh, '1, '1, '1);
    send_word(OpSpareHi, LevelHigh, '1, '1, '1);

    // fill both levels past full, then drain everything under a long receiver hold
    for (int i = 0; i <= QueueDepth; i++) begin
      send_word(OpEnqueue, LevelLow, pick_handle(), pick_handle(), pick_handle());
      send_word(OpEnqueue, LevelHigh, pick_handle(), pick_handle(), pick_handle());
      sent += 2;
    end
    hold_req = 1'b1;
    send_word(OpDrain, LevelLow, '0, '0, '0);
    sent++;

    while (sent < RandomWords) begin
      if (sent >= RandomWords - CalmWords) calm = 1'b1;
      if (!paused && sent >= RandomWords / 2) begin
        paused = 1'b1;
        wait_idle();
      end
      if ($urandom_range(0, 19) == 0) begin
        burst = $urandom_range(8, 20);
        for (int i = 0; i < burst; i++) begin
          send_word(OpEnqueue, LevelW'($urandom_range(0, 1)), pick_handle(), pick_handle(),
                    pick_handle());
        end
        sent += burst;
      end else begin
        send_random(counted);
        if (counted) sent++;
      end
    end

    wait_idle();
    repeat (SettleCycles) @(posedge clk_i);
    if (check_errors == 0) begin
      $display("two_level_priority_task_queue regression: pass");
    end else begin
      $display("two_level_priority_task_queue regression: fail");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/tpq_pkg.sv
sv/tpq_ram.sv
sv/two_level_priority_task_queue.sv
tb/task_queue_checker.sv
tb/two_level_priority_task_queue_tb.sv
